// ----- src/rlde_pkg.sv -----
// Shared types and constants of the run-length decimal text encoder.
`default_nettype none

package rlde_pkg;

   // Command codes on req_opcode
   typedef enum logic [1:0] {
      OP_PUT = 2'd0,
      OP_EOL = 2'd1,
      OP_KEY = 2'd2
   } op_type;

   // ASCII bytes of the text
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // Most bytes delivered for one command
   localparam int RESULT_LIMIT = 24;
   localparam int EMIT_CNT_W   = 5;

   // Output pieces of one job, emitted in index order
   localparam int SEG_LEAD  = 0;  // space in place of a missing key
   localparam int SEG_SIGN  = 1;  // minus sign of the run value
   localparam int SEG_VAL   = 2;  // decimal digits of the run magnitude
   localparam int SEG_PSP   = 3;  // space of a digit pair
   localparam int SEG_PDIG  = 4;  // repeated digit of a digit pair
   localparam int SEG_BANG  = 5;  // '!' before the run count
   localparam int SEG_CNT   = 6;  // decimal digits of the run count
   localparam int SEG_TRAIL = 7;  // space after a flushed run
   localparam int SEG_NL    = 8;  // newline
   localparam int SEG_KEY   = 9;  // key byte of a new line
   localparam int SEG_COUNT = 10;

   typedef logic [SEG_COUNT-1:0] seg_mask_type;

   // Control part of one job passed from front to back
   typedef struct packed {
      seg_mask_type segs;
      logic [3:0]   pair_digit;
      logic [7:0]   key;
   } job_ctl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_BYTE,
      BK_CONV,
      BK_SCAN,
      BK_DIGIT
   } back_state_type;

endpackage

`default_nettype wire

// ----- src/rlde_front.sv -----
// Command front end: holds the run state and turns each command into a job.
`default_nettype none

module rlde_front #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic signed [31:0]            req_number_value,
   input  wire logic [7:0]                    req_key_char,
   input  wire logic                          q_full,
   output logic                               q_push,
   output rlde_pkg::job_ctl_type              job_ctl,
   output logic [VALUE_WIDTH-1:0]             job_mag,
   output logic [COUNT_WIDTH-1:0]             job_count
);

   logic [COUNT_WIDTH-1:0] run_count_ff, run_count_in;
   logic [VALUE_WIDTH-1:0] run_value_ff, run_value_in;
   logic                   at_line_start_ff, at_line_start_in;

   logic signed [63:0]     num_wide;
   logic [VALUE_WIDTH-1:0] num;
   logic                   accept;
   logic                   has_run, cnt_one, cnt_two, cnt_max, multi;
   logic                   v_nz, v_neg, v_small, pair_run, value_eq;
   logic                   flush, eol_val;
   rlde_pkg::seg_mask_type segs;

   assign num_wide  = 64'(req_number_value);
   assign num       = num_wide[VALUE_WIDTH-1:0];
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   assign has_run  = |run_count_ff;
   assign cnt_one  = run_count_ff == COUNT_WIDTH'(1);
   assign cnt_two  = run_count_ff == COUNT_WIDTH'(2);
   assign cnt_max  = &run_count_ff;
   assign multi    = has_run && !cnt_one;
   assign v_nz     = |run_value_ff;
   assign v_neg    = run_value_ff[VALUE_WIDTH-1];
   assign v_small  = !v_neg && v_nz && (run_value_ff <= VALUE_WIDTH'(9));
   assign pair_run = cnt_two && v_small;
   assign value_eq = run_value_ff == num;
   assign flush    = has_run && !(value_eq && !cnt_max);
   assign eol_val  = has_run && v_nz;

   always_comb begin
      segs             = '0;
      run_count_in     = run_count_ff;
      run_value_in     = run_value_ff;
      at_line_start_in = at_line_start_ff;
      unique case (req_opcode)
         rlde_pkg::OP_PUT: begin
            segs[rlde_pkg::SEG_LEAD]  = at_line_start_ff;
            segs[rlde_pkg::SEG_VAL]   = flush && (cnt_one || v_nz);
            segs[rlde_pkg::SEG_SIGN]  = flush && (cnt_one || v_nz) && v_neg;
            segs[rlde_pkg::SEG_PSP]   = flush && multi && pair_run;
            segs[rlde_pkg::SEG_PDIG]  = flush && multi && pair_run;
            segs[rlde_pkg::SEG_BANG]  = flush && multi && !pair_run;
            segs[rlde_pkg::SEG_CNT]   = flush && multi && !pair_run;
            segs[rlde_pkg::SEG_TRAIL] = flush;
            at_line_start_in = 1'b0;
            run_value_in     = num;
            run_count_in     = (flush || !has_run) ? COUNT_WIDTH'(1)
                                                   : run_count_ff + COUNT_WIDTH'(1);
         end
         rlde_pkg::OP_EOL: begin
            segs[rlde_pkg::SEG_VAL]  = eol_val;
            segs[rlde_pkg::SEG_SIGN] = eol_val && v_neg;
            segs[rlde_pkg::SEG_PSP]  = eol_val && multi && pair_run;
            segs[rlde_pkg::SEG_PDIG] = eol_val && multi && pair_run;
            segs[rlde_pkg::SEG_BANG] = eol_val && multi && !pair_run;
            segs[rlde_pkg::SEG_CNT]  = eol_val && multi && !pair_run;
            segs[rlde_pkg::SEG_NL]   = 1'b1;
            run_count_in     = '0;
            at_line_start_in = 1'b1;
         end
         rlde_pkg::OP_KEY: begin
            // Close the open line before the key
            if (!at_line_start_ff) begin
               segs[rlde_pkg::SEG_VAL]  = eol_val;
               segs[rlde_pkg::SEG_SIGN] = eol_val && v_neg;
               segs[rlde_pkg::SEG_PSP]  = eol_val && multi && pair_run;
               segs[rlde_pkg::SEG_PDIG] = eol_val && multi && pair_run;
               segs[rlde_pkg::SEG_BANG] = eol_val && multi && !pair_run;
               segs[rlde_pkg::SEG_CNT]  = eol_val && multi && !pair_run;
               segs[rlde_pkg::SEG_NL]   = 1'b1;
               run_count_in = '0;
            end
            segs[rlde_pkg::SEG_KEY] = 1'b1;
            at_line_start_in = 1'b0;
         end
         default: begin
            segs = '0;
         end
      endcase
   end

   assign q_push             = accept && (|segs);
   assign job_ctl.segs       = segs;
   assign job_ctl.pair_digit = run_value_ff[3:0];
   assign job_ctl.key        = req_key_char;
   assign job_mag            = v_neg ? (~run_value_ff + VALUE_WIDTH'(1)) : run_value_ff;
   assign job_count          = run_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff     <= '0;
         run_value_ff     <= '1;
         at_line_start_ff <= 1'b1;
      end else if (accept) begin
         run_count_ff     <= run_count_in;
         run_value_ff     <= run_value_in;
         at_line_start_ff <= at_line_start_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/rlde_queue.sv -----
// Two-entry job queue between the front end and the byte sequencer.
`default_nettype none

module rlde_queue #(
   parameter int DATA_WIDTH = 72
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  pop,
   output logic [DATA_WIDTH-1:0]      rd_data,
   output logic                       full,
   output logic                       not_empty
);

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;

   assign full      = fill_ff == 2'd2;
   assign not_empty = fill_ff != 2'd0;
   assign rd_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/rlde_back.sv -----
// Byte sequencer: walks a job's pieces and converts numbers to decimal.
`default_nettype none

module rlde_back #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   output logic                        q_pop,
   input  wire rlde_pkg::job_ctl_type  q_ctl,
   input  wire logic [VALUE_WIDTH-1:0] q_mag,
   input  wire logic [COUNT_WIDTH-1:0] q_count,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_byte
);

   localparam int CONV_WIDTH = (VALUE_WIDTH > COUNT_WIDTH) ? VALUE_WIDTH : COUNT_WIDTH;
   localparam int CONV_STEPS = (CONV_WIDTH + 3) / 4;
   localparam int CONV_PAD   = CONV_STEPS * 4;
   localparam int DEC_DIGITS = (CONV_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_W      = DEC_DIGITS * 4;
   localparam int PTR_W      = $clog2(DEC_DIGITS);
   localparam int STEP_W     = $clog2(CONV_STEPS);
   localparam int ECW        = rlde_pkg::EMIT_CNT_W;

   rlde_pkg::back_state_type state_ff, state_in;

   rlde_pkg::job_ctl_type  ctl_ff, ctl_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [CONV_PAD-1:0]    src_ff, src_in;
   logic [BCD_W-1:0]       digit_buffer_ff, digit_buffer_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [ECW-1:0]         emit_cnt_ff, emit_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_out_byte_ff, rsp_out_byte_in;
   logic                   rsp_last_byte_ff, rsp_last_byte_in;

   rlde_pkg::seg_mask_type low_seg, mask_after;
   logic                   out_free, at_limit, conv_seg, seg_last, digit_last;
   logic [7:0]             seg_byte;
   logic [BCD_W-1:0]       bcd_step;
   logic [CONV_PAD-1:0]    src_step;
   logic [PTR_W-1:0]       top_digit;

   // Piece decode shared by next-state and datapath
   always_comb begin
      low_seg    = ctl_ff.segs & (~ctl_ff.segs + rlde_pkg::seg_mask_type'(1));
      mask_after = ctl_ff.segs & ~low_seg;
      out_free   = !rsp_valid_ff || !rsp_stall;
      at_limit   = emit_cnt_ff == ECW'(rlde_pkg::RESULT_LIMIT - 1);
      conv_seg   = low_seg[rlde_pkg::SEG_VAL] || low_seg[rlde_pkg::SEG_CNT];
      seg_last   = (mask_after == '0) || at_limit;
      digit_last = ((ptr_ff == '0) && (mask_after == '0)) || at_limit;
      priority if (low_seg[rlde_pkg::SEG_SIGN]) begin
         seg_byte = rlde_pkg::CHAR_MINUS;
      end else if (low_seg[rlde_pkg::SEG_PDIG]) begin
         seg_byte = rlde_pkg::CHAR_ZERO + {4'd0, ctl_ff.pair_digit};
      end else if (low_seg[rlde_pkg::SEG_BANG]) begin
         seg_byte = rlde_pkg::CHAR_BANG;
      end else if (low_seg[rlde_pkg::SEG_NL]) begin
         seg_byte = rlde_pkg::CHAR_NL;
      end else if (low_seg[rlde_pkg::SEG_KEY]) begin
         seg_byte = ctl_ff.key;
      end else begin
         seg_byte = rlde_pkg::CHAR_SPACE;
      end
   end

   // Four double-dabble bit steps per cycle
   always_comb begin
      bcd_step = digit_buffer_ff;
      src_step = src_ff;
      for (int b = 0; b < 4; b++) begin
         for (int d = 0; d < DEC_DIGITS; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_W-2:0], src_step[CONV_PAD-1]};
         src_step = {src_step[CONV_PAD-2:0], 1'b0};
      end
   end

   // Highest nonzero digit; digit zero always prints
   always_comb begin
      top_digit = '0;
      for (int d = 0; d < DEC_DIGITS; d++) begin
         if (digit_buffer_ff[d*4 +: 4] != 4'd0) begin
            top_digit = PTR_W'(d);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlde_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = rlde_pkg::BK_BYTE;
            end
         end
         rlde_pkg::BK_BYTE: begin
            if (conv_seg) begin
               state_in = rlde_pkg::BK_CONV;
            end else if (out_free && seg_last) begin
               state_in = rlde_pkg::BK_IDLE;
            end
         end
         rlde_pkg::BK_CONV: begin
            if (step_ff == '0) begin
               state_in = rlde_pkg::BK_SCAN;
            end
         end
         rlde_pkg::BK_SCAN: begin
            state_in = rlde_pkg::BK_DIGIT;
         end
         rlde_pkg::BK_DIGIT: begin
            if (out_free) begin
               if (digit_last) begin
                  state_in = rlde_pkg::BK_IDLE;
               end else if (ptr_ff == '0) begin
                  state_in = rlde_pkg::BK_BYTE;
               end
            end
         end
         default: begin
            state_in = rlde_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop            = 1'b0;
      ctl_in           = ctl_ff;
      mag_in           = mag_ff;
      count_in         = count_ff;
      src_in           = src_ff;
      digit_buffer_in  = digit_buffer_ff;
      step_in          = step_ff;
      ptr_in           = ptr_ff;
      emit_cnt_in      = emit_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_out_byte_in  = rsp_out_byte_ff;
      rsp_last_byte_in = rsp_last_byte_ff;
      unique case (state_ff)
         rlde_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               ctl_in      = q_ctl;
               mag_in      = q_mag;
               count_in    = q_count;
               emit_cnt_in = '0;
            end
         end
         rlde_pkg::BK_BYTE: begin
            if (conv_seg) begin
               src_in          = low_seg[rlde_pkg::SEG_VAL] ? CONV_PAD'(mag_ff)
                                                            : CONV_PAD'(count_ff);
               digit_buffer_in = '0;
               step_in         = STEP_W'(CONV_STEPS - 1);
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_out_byte_in  = seg_byte;
               rsp_last_byte_in = seg_last;
               ctl_in.segs      = mask_after;
               emit_cnt_in      = emit_cnt_ff + ECW'(1);
            end
         end
         rlde_pkg::BK_CONV: begin
            digit_buffer_in = bcd_step;
            src_in          = src_step;
            step_in         = step_ff - STEP_W'(1);
         end
         rlde_pkg::BK_SCAN: begin
            ptr_in = top_digit;
         end
         rlde_pkg::BK_DIGIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_out_byte_in  = rlde_pkg::CHAR_ZERO + {4'd0, digit_buffer_ff[ptr_ff*4 +: 4]};
               rsp_last_byte_in = digit_last;
               emit_cnt_in      = emit_cnt_ff + ECW'(1);
               if (ptr_ff == '0) begin
                  ctl_in.segs = mask_after;
               end else begin
                  ptr_in = ptr_ff - PTR_W'(1);
               end
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlde_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff           <= ctl_in;
      mag_ff           <= mag_in;
      count_ff         <= count_in;
      src_ff           <= src_in;
      digit_buffer_ff  <= digit_buffer_in;
      step_ff          <= step_in;
      ptr_ff           <= ptr_in;
      emit_cnt_ff      <= emit_cnt_in;
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_last_byte_ff <= rsp_last_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_last_byte = rsp_last_byte_ff;

endmodule

`default_nettype wire

// ----- src/run_length_decimal_text_encoder.sv -----
// Run-length decimal text encoder: the top level, tying front, queue and sequencer.
//
// Commands (put number, end line, start line with key) are taken by a front end
// that keeps the pending run and turns each command into a job combinationally; a
// two-entry queue holds jobs for the byte sequencer, which sends bytes out one
// per cycle through an output register while the output does not stall and no
// number is being converted, the last byte of a command marked by rsp_last_byte.
// A command that only extends a run produces no job and no byte. Per job the
// sequencer first loads it, then sends plain bytes, and for each decimal number
// (run value, run count) sets up, runs and scans the double-dabble conversion
// (at the wider of VALUE_WIDTH and COUNT_WIDTH, four bits a cycle) before it
// sends the digits; up to 24 bytes per command are delivered. req_stall
// rises only while the queue is full.
`default_nettype none

module run_length_decimal_text_encoder #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_number_value,
   input  wire logic [7:0]         req_key_char,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_byte
);

   localparam int CTL_W = $bits(rlde_pkg::job_ctl_type);
   localparam int JOB_W = CTL_W + VALUE_WIDTH + COUNT_WIDTH;

   rlde_pkg::job_ctl_type  push_ctl, pop_ctl;
   logic [VALUE_WIDTH-1:0] push_mag, pop_mag;
   logic [COUNT_WIDTH-1:0] push_count, pop_count;
   logic                   q_push, q_pop, q_full, q_not_empty;
   logic [JOB_W-1:0]       q_wr_data, q_rd_data;

   rlde_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_number_value (req_number_value),
      .req_key_char     (req_key_char),
      .q_full           (q_full),
      .q_push           (q_push),
      .job_ctl          (push_ctl),
      .job_mag          (push_mag),
      .job_count        (push_count)
   );

   assign q_wr_data = {push_ctl, push_mag, push_count};

   rlde_queue #(
      .DATA_WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (q_wr_data),
      .pop       (q_pop),
      .rd_data   (q_rd_data),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   assign pop_ctl   = q_rd_data[JOB_W-1 -: CTL_W];
   assign pop_mag   = q_rd_data[COUNT_WIDTH +: VALUE_WIDTH];
   assign pop_count = q_rd_data[COUNT_WIDTH-1:0];

   rlde_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_not_empty),
      .q_pop         (q_pop),
      .q_ctl         (pop_ctl),
      .q_mag         (pop_mag),
      .q_count       (pop_count),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire
